>>> rtl/necir_pkg.sv
`timescale 1ns / 1ps
// necir_pkg: shared types, constants and helper functions for the nec ir frame decoder
// no dependencies

package necir_pkg;

    // default measured duration width in ticks
    localparam int DURATION_WIDTH_DEF = 15;
    // widest microsecond value for the largest duration width
    localparam int US_MAX_W = 17;
    // window compare width (target + slack and us + slack)
    localparam int WIN_W = US_MAX_W + 1;

    // classification queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // frame layout
    localparam int FRAME_BITS = 32;
    localparam int BIT_IDX_W = $clog2(FRAME_BITS);
    localparam int WORD_BITS = 16;

    // configuration port
    localparam int NUM_REGS = 8;
    localparam int PADDR_W = $clog2(NUM_REGS) + 2;
    localparam int PDATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_EXPECTED_ADDRESS = 3'd0;
    localparam logic [2:0] REG_SLACK_US         = 3'd1;
    localparam logic [2:0] REG_HEADER_MARK_US   = 3'd2;
    localparam logic [2:0] REG_HEADER_SPACE_US  = 3'd3;
    localparam logic [2:0] REG_ONE_MARK_US      = 3'd4;
    localparam logic [2:0] REG_ONE_SPACE_US     = 3'd5;
    localparam logic [2:0] REG_ZERO_MARK_US     = 3'd6;
    localparam logic [2:0] REG_ZERO_SPACE_US    = 3'd7;

    // register reset values
    localparam logic [15:0] RST_EXPECTED_ADDRESS = 16'd0;
    localparam logic [11:0] RST_SLACK_US         = 12'd100;
    localparam logic [15:0] RST_HEADER_MARK_US   = 16'd9600;
    localparam logic [15:0] RST_HEADER_SPACE_US  = 16'd4480;
    localparam logic [15:0] RST_ONE_MARK_US      = 16'd590;
    localparam logic [15:0] RST_ONE_SPACE_US     = 16'd1690;
    localparam logic [15:0] RST_ZERO_MARK_US     = 16'd550;
    localparam logic [15:0] RST_ZERO_SPACE_US    = 16'd620;

    // result status codes
    localparam logic [2:0] STATUS_OK             = 3'd0;
    localparam logic [2:0] STATUS_BAD_ADDR_BIT   = 3'd1;
    localparam logic [2:0] STATUS_BAD_CMD_BIT    = 3'd2;
    localparam logic [2:0] STATUS_ADDR_CHECK     = 3'd3;
    localparam logic [2:0] STATUS_CMD_CHECK      = 3'd4;
    localparam logic [2:0] STATUS_FOREIGN_ADDR   = 3'd5;

    // timing configuration
    typedef struct packed {
        logic [15:0] expected_address;
        logic [11:0] slack_us;
        logic [15:0] header_mark_us;
        logic [15:0] header_space_us;
        logic [15:0] one_mark_us;
        logic [15:0] one_space_us;
        logic [15:0] zero_mark_us;
        logic [15:0] zero_space_us;
    } t_cfg;

    // classified pulse pair handed from front to back
    typedef struct packed {
        logic hdr_match;
        logic one_match;
        logic zero_match;
    } t_pair_class;

    // exclusive window test: target - slack < us < target + slack
    function automatic logic in_window(input logic [US_MAX_W-1:0] us,
                                       input logic [15:0] target,
                                       input logic [11:0] slack);
        logic [WIN_W-1:0] hi;
        logic [WIN_W-1:0] us_plus;
        hi      = WIN_W'(target) + WIN_W'(slack);
        us_plus = WIN_W'(us) + WIN_W'(slack);
        return (WIN_W'(us) < hi) && (us_plus > WIN_W'(target));
    endfunction

    // high byte must be the complement of the low byte
    function automatic logic word_ok(input logic [15:0] w);
        return w[15:8] == ~w[7:0];
    endfunction

endpackage

>>> rtl/necir_if.sv
`timescale 1ns / 1ps
// necir_pair_if and necir_result_if: valid/ready channels of the nec ir frame decoder
// depends on necir_pkg

// measured pulse pair channel
interface necir_pair_if #(
    parameter int DUR_W = necir_pkg::DURATION_WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic             mark_level;
    logic [DUR_W-1:0] mark_ticks;
    logic             space_level;
    logic [DUR_W-1:0] space_ticks;

    modport source (output valid, output mark_level, output mark_ticks,
                    output space_level, output space_ticks, input ready);
    modport sink   (input valid, input mark_level, input mark_ticks,
                    input space_level, input space_ticks, output ready);
endinterface

// decoded frame result channel
interface necir_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [15:0] address_word;

    modport source (output valid, output status, output command,
                    output address_word, input ready);
    modport sink   (input valid, input status, input command,
                    input address_word, output ready);
endinterface

>>> rtl/nec_ir_frame_decoder_core.sv
`timescale 1ns / 1ps
// nec_ir_frame_decoder_core: top level with configuration registers, front, queue and back
// depends on necir_pkg, necir_if, necir_front, necir_queue and necir_back
// throughput: one pulse pair per cycle while the queue has room; the front classifies
// in the accepting cycle and the back registers a result from the queued classes
// a four-entry classification queue lets input run while the result side stalls
// reset: synchronous active-low; registers take their defaults, decoder waits for a header

module nec_ir_frame_decoder_core #(
    parameter int DURATION_WIDTH = necir_pkg::DURATION_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    necir_pair_if.sink                        i_pair,
    necir_result_if.source                    o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [necir_pkg::PADDR_W-1:0]     paddr,
    input  logic [necir_pkg::PDATA_W-1:0]     pwdata,
    output logic [necir_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);
    import necir_pkg::*;

    t_cfg        r_cfg;
    t_cfg        n_cfg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_valid;
    t_pair_class front_class;
    t_pair_class head_class;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_EXPECTED_ADDRESS: n_cfg.expected_address = pwdata[15:0];
                REG_SLACK_US:         n_cfg.slack_us         = pwdata[11:0];
                REG_HEADER_MARK_US:   n_cfg.header_mark_us   = pwdata[15:0];
                REG_HEADER_SPACE_US:  n_cfg.header_space_us  = pwdata[15:0];
                REG_ONE_MARK_US:      n_cfg.one_mark_us      = pwdata[15:0];
                REG_ONE_SPACE_US:     n_cfg.one_space_us     = pwdata[15:0];
                REG_ZERO_MARK_US:     n_cfg.zero_mark_us     = pwdata[15:0];
                REG_ZERO_SPACE_US:    n_cfg.zero_space_us    = pwdata[15:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_address <= RST_EXPECTED_ADDRESS;
            r_cfg.slack_us         <= RST_SLACK_US;
            r_cfg.header_mark_us   <= RST_HEADER_MARK_US;
            r_cfg.header_space_us  <= RST_HEADER_SPACE_US;
            r_cfg.one_mark_us      <= RST_ONE_MARK_US;
            r_cfg.one_space_us     <= RST_ONE_SPACE_US;
            r_cfg.zero_mark_us     <= RST_ZERO_MARK_US;
            r_cfg.zero_space_us    <= RST_ZERO_SPACE_US;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // register read mux
    always_comb begin
        case (reg_idx)
            REG_EXPECTED_ADDRESS: prdata = PDATA_W'(r_cfg.expected_address);
            REG_SLACK_US:         prdata = PDATA_W'(r_cfg.slack_us);
            REG_HEADER_MARK_US:   prdata = PDATA_W'(r_cfg.header_mark_us);
            REG_HEADER_SPACE_US:  prdata = PDATA_W'(r_cfg.header_space_us);
            REG_ONE_MARK_US:      prdata = PDATA_W'(r_cfg.one_mark_us);
            REG_ONE_SPACE_US:     prdata = PDATA_W'(r_cfg.one_space_us);
            REG_ZERO_MARK_US:     prdata = PDATA_W'(r_cfg.zero_mark_us);
            REG_ZERO_SPACE_US:    prdata = PDATA_W'(r_cfg.zero_space_us);
            default:              prdata = '0;
        endcase
    end

    // pair classification
    necir_front #(
        .DUR_W (DURATION_WIDTH)
    ) u_front (
        .i_pair   (i_pair),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_class  (front_class)
    );

    // decoupling queue
    necir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_class (front_class),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_class (head_class)
    );

    // frame assembly and result
    necir_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_class            (head_class),
        .i_expected_address (r_cfg.expected_address),
        .o_pop              (q_pop),
        .o_result           (o_result)
    );

endmodule

>>> rtl/necir_front.sv
`timescale 1ns / 1ps
// necir_front: takes pulse pairs, converts ticks to microseconds and matches timing windows
// depends on necir_pkg and necir_if

module necir_front #(
    parameter int DUR_W = necir_pkg::DURATION_WIDTH_DEF
) (
    necir_pair_if.sink              i_pair,
    input  necir_pkg::t_cfg         i_cfg,
    input  logic                    i_q_full,
    output logic                    o_push,
    output necir_pkg::t_pair_class  o_class
);
    import necir_pkg::*;

    logic [DUR_W:0]    mark_us_raw;
    logic [DUR_W:0]    space_us_raw;
    logic [US_MAX_W-1:0] mark_us;
    logic [US_MAX_W-1:0] space_us;
    logic              levels_ok;

    // ticks * 10 / 8 == ticks + ticks / 4
    assign mark_us_raw  = (DUR_W+1)'(i_pair.mark_ticks) + (DUR_W+1)'(i_pair.mark_ticks >> 2);
    assign space_us_raw = (DUR_W+1)'(i_pair.space_ticks) + (DUR_W+1)'(i_pair.space_ticks >> 2);
    assign mark_us      = US_MAX_W'(mark_us_raw);
    assign space_us     = US_MAX_W'(space_us_raw);

    // active-low mark followed by an idle space
    assign levels_ok = !i_pair.mark_level && i_pair.space_level;

    // window matches against every target
    always_comb begin
        o_class.hdr_match  = levels_ok
                           && in_window(mark_us, i_cfg.header_mark_us, i_cfg.slack_us)
                           && in_window(space_us, i_cfg.header_space_us, i_cfg.slack_us);
        o_class.one_match  = levels_ok
                           && in_window(mark_us, i_cfg.one_mark_us, i_cfg.slack_us)
                           && in_window(space_us, i_cfg.one_space_us, i_cfg.slack_us);
        o_class.zero_match = levels_ok
                           && in_window(mark_us, i_cfg.zero_mark_us, i_cfg.slack_us)
                           && in_window(space_us, i_cfg.zero_space_us, i_cfg.slack_us);
    end

    // accept whenever the queue has room
    assign i_pair.ready = !i_q_full;
    assign o_push       = i_pair.valid && !i_q_full;

endmodule

>>> rtl/necir_queue.sv
`timescale 1ns / 1ps
// necir_queue: small fifo of classified pulse pairs between front and back
// depends on necir_pkg

module necir_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  necir_pkg::t_pair_class  i_class,
    input  logic                    i_pop,
    output logic                    o_full,
    output logic                    o_valid,
    output necir_pkg::t_pair_class  o_class
);
    import necir_pkg::*;

    t_pair_class       r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_class = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({i_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_class;
        end
    end

endmodule

>>> rtl/necir_back.sv
`timescale 1ns / 1ps
// necir_back: frame sequencer, bit assembly, word checks and registered result output
// depends on necir_pkg and necir_if

module necir_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  necir_pkg::t_pair_class  i_class,
    input  logic [15:0]             i_expected_address,
    output logic                    o_pop,
    necir_result_if.source          o_result
);
    import necir_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FRAME = 2'b10
    } t_back_state;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [BIT_IDX_W-1:0] r_bits;
    logic [BIT_IDX_W-1:0] n_bits;
    logic [FRAME_BITS-1:0] r_shift;
    logic [FRAME_BITS-1:0] n_shift;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [2:0]           r_status;
    logic [2:0]           n_status;
    logic [7:0]           r_command;
    logic [7:0]           n_command;
    logic [15:0]          r_address;
    logic [15:0]          n_address;
    logic                 emit;
    logic                 data_bit;
    logic [FRAME_BITS-1:0] set_mask;
    logic [FRAME_BITS-1:0] full_shift;
    logic [15:0]          addr_word;
    logic [15:0]          cmd_word;

    // pop when the output register is free or being drained
    assign o_pop = i_q_valid && (!r_out_valid || o_result.ready);

    assign data_bit   = i_class.one_match;
    assign set_mask   = FRAME_BITS'(data_bit) << r_bits;
    assign full_shift = r_shift | set_mask;
    assign addr_word  = full_shift[WORD_BITS-1:0];
    assign cmd_word   = full_shift[FRAME_BITS-1:WORD_BITS];

    // frame sequencing
    always_comb begin
        n_state   = r_state;
        n_bits    = r_bits;
        n_shift   = r_shift;
        emit      = 1'b0;
        n_status  = STATUS_OK;
        n_command = '0;
        n_address = r_shift[WORD_BITS-1:0];
        if (o_pop) begin
            case (r_state)
                ST_IDLE: begin
                    if (i_class.hdr_match) begin
                        n_state = ST_FRAME;
                        n_bits  = '0;
                        n_shift = '0;
                    end
                end
                ST_FRAME: begin
                    if (i_class.one_match || i_class.zero_match) begin
                        n_shift = full_shift;
                        if (r_bits == BIT_IDX_W'(FRAME_BITS - 1)) begin
                            // full frame: checks in priority order
                            emit      = 1'b1;
                            n_state   = ST_IDLE;
                            n_bits    = '0;
                            n_address = addr_word;
                            if (!word_ok(addr_word)) begin
                                n_status = STATUS_ADDR_CHECK;
                            end else if (!word_ok(cmd_word)) begin
                                n_status = STATUS_CMD_CHECK;
                            end else if (addr_word != i_expected_address) begin
                                n_status = STATUS_FOREIGN_ADDR;
                            end else begin
                                n_status  = STATUS_OK;
                                n_command = cmd_word[7:0];
                            end
                        end else begin
                            n_bits = r_bits + 1'b1;
                        end
                    end else begin
                        // bad pair aborts the frame
                        emit    = 1'b1;
                        n_state = ST_IDLE;
                        n_bits  = '0;
                        if (r_bits < BIT_IDX_W'(WORD_BITS)) begin
                            n_status = STATUS_BAD_ADDR_BIT;
                        end else begin
                            n_status = STATUS_BAD_CMD_BIT;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                    n_bits  = '0;
                end
            endcase
        end
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bits      <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bits      <= n_bits;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status  <= n_status;
            r_command <= n_command;
            r_address <= n_address;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_status;
    assign o_result.command      = r_command;
    assign o_result.address_word = r_address;

endmodule
